### rtl/core/fssm_pkg.sv
// Package for the fan speed smoother: opcodes, register indexes, config
// struct and fixed arithmetic constants. No dependencies.

package fssm_pkg;

   // Item operations
   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_SEED   = 2'd1,
      OP_READ   = 2'd2
   } opcode_type;

   // Register indexes on the csr channel
   typedef enum logic [1:0] {
      CSR_ALPHA           = 2'd0,
      CSR_STEP_LIMIT      = 2'd1,
      CSR_ZERO_FLOOR      = 2'd2,
      CSR_ACTIVE_CHANNELS = 2'd3
   } csr_index_type;

   // Filter settings handed to the step datapath
   typedef struct packed {
      logic [10:0] alpha;
      logic [15:0] slew_max;
      logic [15:0] zero_floor;
   } cfg_type;

   localparam logic [15:0] SCALE_LIMIT  = 16'd255;
   localparam logic [15:0] SCALE_FACTOR = 16'd100;
   localparam int          GAIN_SHIFT   = 10;
   localparam logic [15:0] RPM_MAX      = 16'hFFFF;

   // Register reset values
   localparam logic [10:0] ALPHA_RST      = 11'd20;
   localparam logic [15:0] STEP_LIMIT_RST = 16'd10;
   localparam logic [15:0] ZERO_FLOOR_RST = 16'd50;
   localparam logic [1:0]  ACTIVE_CH_RST  = 2'd2;

endpackage

### rtl/core/fssm_if.sv
// Channel interfaces for the fan speed smoother: request, response and
// register write. No dependencies.

interface fssm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic        channel;
   logic [15:0] raw_reading;

   modport source (output valid, opcode, channel, raw_reading, input ready);
   modport sink   (input valid, opcode, channel, raw_reading, output ready);
endinterface

interface fssm_rsp_if;
   logic        valid;
   logic        ready;
   logic        channel_echo;
   logic [15:0] smoothed_rpm;
   logic        bad_channel;

   modport source (output valid, channel_echo, smoothed_rpm, bad_channel, input ready);
   modport sink   (input valid, channel_echo, smoothed_rpm, bad_channel, output ready);
endinterface

interface fssm_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

### rtl/core/fan_speed_slew_limited_smoother.sv
// Fan speed smoother top level: input register, step datapath, per-channel
// speed registers and output register. Depends on fssm_pkg, fssm_if, fssm_step.
// A request is held in the input register, then its result in the output register;
// a full output register that is not draining keeps the request in the input register.
// Throughput: one item per cycle; the input register refills while the output
// register drains, so the only stall is a response side not taking results.
// Reset clears all speeds to 0 and loads register defaults.

module fan_speed_slew_limited_smoother
   import fssm_pkg::*;
#(
   parameter int CHANNELS = 2
)
(
   input  logic        clock,
   input  logic        reset,
   fssm_req_if.sink    req_chan,
   fssm_rsp_if.source  rsp_chan,
   fssm_csr_if.sink    csr_chan
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(CHANNELS + 1);

   cfg_type     cfg_ff;
   logic [1:0]  active_ff;

   logic        in_valid_ff;
   logic [1:0]  in_op_ff;
   logic        in_chan_ff;
   logic [15:0] in_raw_ff;

   logic        rsp_valid_ff;
   logic        rsp_chan_ff;
   logic [15:0] rsp_rpm_ff;
   logic        rsp_bad_ff;

   logic [15:0] speed_ff [CHANNELS];

   logic             advance;
   logic             bad;
   logic [IDX_W-1:0] in_idx;
   logic [15:0]      cur_speed;
   logic [15:0]      speed_in;

   // Register writes are always taken
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha      <= ALPHA_RST;
         cfg_ff.slew_max   <= STEP_LIMIT_RST;
         cfg_ff.zero_floor <= ZERO_FLOOR_RST;
         active_ff         <= ACTIVE_CH_RST;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_ALPHA:           cfg_ff.alpha      <= csr_chan.wdata[10:0];
            CSR_STEP_LIMIT:      cfg_ff.slew_max   <= csr_chan.wdata;
            CSR_ZERO_FLOOR:      cfg_ff.zero_floor <= csr_chan.wdata;
            CSR_ACTIVE_CHANNELS: active_ff         <= csr_chan.wdata[1:0];
            default:             active_ff         <= active_ff;
         endcase
      end
   end

   // Advance the input stage when the output register is free or draining
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   // Hold the request payload
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_op_ff   <= req_chan.opcode;
         in_chan_ff <= req_chan.channel;
         in_raw_ff  <= req_chan.raw_reading;
      end
   end

   // Reject channels beyond the active count or the built channel count
   assign bad = ({1'b0, in_chan_ff} >= active_ff) ||
                (CNT_W'(in_chan_ff) >= CNT_W'(CHANNELS));
   assign in_idx    = IDX_W'(in_chan_ff);
   assign cur_speed = speed_ff[in_idx];

   fssm_step u_step (
      .cfg         (cfg_ff),
      .opcode      (opcode_type'(in_op_ff)),
      .raw_reading (in_raw_ff),
      .cur_speed   (cur_speed),
      .next_speed  (speed_in)
   );

   // Write back the channel speed on a good transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            speed_ff[i] <= 16'd0;
         end
      end else if (advance && !bad) begin
         speed_ff[in_idx] <= speed_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_chan_ff <= in_chan_ff;
         rsp_rpm_ff  <= bad ? 16'd0 : speed_in;
         rsp_bad_ff  <= bad;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.channel_echo = rsp_chan_ff;
   assign rsp_chan.smoothed_rpm = rsp_rpm_ff;
   assign rsp_chan.bad_channel  = rsp_bad_ff;

   // The input side never waits on an empty output register
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_chan.ready)
      else $error("request stalled with empty output register");

   // A good result matches the stored channel speed
   a_result_written: assert property (@(posedge clock) disable iff (reset)
      advance && !bad |=> rsp_valid_ff && (speed_ff[$past(in_idx)] == rsp_rpm_ff))
      else $error("result differs from stored speed");

   // A rejected channel reports zero speed
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_rpm_ff == 16'd0)
      else $error("rejected channel reports nonzero speed");

endmodule

### rtl/core/fssm_step.sv
// Combinational step datapath: scales a raw reading, applies the slew
// limited smoothing step, seed or hold. Depends on fssm_pkg.

module fssm_step
   import fssm_pkg::*;
(
   input  cfg_type     cfg,
   input  opcode_type  opcode,
   input  logic [15:0] raw_reading,
   input  logic [15:0] cur_speed,
   output logic [15:0] next_speed
);

   logic [15:0]        rpm;
   logic signed [16:0] delta;
   logic signed [28:0] prod;
   logic signed [18:0] step;
   logic signed [19:0] step_ext;
   logic signed [19:0] lim;
   logic signed [19:0] step_clamped;
   logic signed [20:0] sum;
   logic [15:0]        sum_sat;
   logic [15:0]        filtered;

   // Scale hundreds-of-RPM readings, pass the rest through
   always_comb begin
      if (raw_reading >= 16'd1 && raw_reading <= SCALE_LIMIT) begin
         rpm = 16'({8'd0, raw_reading[7:0]} * SCALE_FACTOR);
      end else begin
         rpm = raw_reading;
      end
   end

   // Gain the difference; the upper product bits give floor(prod / 1024)
   assign delta    = $signed({1'b0, rpm}) - $signed({1'b0, cur_speed});
   assign prod     = delta * $signed({1'b0, cfg.alpha});
   assign step     = $signed(prod[28:GAIN_SHIFT]);
   assign step_ext = {step[18], step};
   assign lim      = $signed({4'd0, cfg.slew_max});

   // Clamp the step to the slew limit
   always_comb begin
      if (step_ext > lim) begin
         step_clamped = lim;
      end else if (step_ext < -lim) begin
         step_clamped = -lim;
      end else begin
         step_clamped = step_ext;
      end
   end

   // Add, saturate to the 16-bit range, then drop speeds under the floor
   assign sum = $signed({5'd0, cur_speed}) + $signed({step_clamped[19], step_clamped});

   always_comb begin
      if (sum < 0) begin
         sum_sat = 16'd0;
      end else if (sum > $signed({5'd0, RPM_MAX})) begin
         sum_sat = RPM_MAX;
      end else begin
         sum_sat = sum[15:0];
      end
      filtered = (sum_sat < cfg.zero_floor) ? 16'd0 : sum_sat;
   end

   // Select by operation
   always_comb begin
      case (opcode)
         OP_UPDATE: next_speed = filtered;
         OP_SEED:   next_speed = rpm;
         default:   next_speed = cur_speed;
      endcase
   end

endmodule

### tb/tb_fan_speed_slew_limited_smoother.sv
// Self-checking testbench for the fan speed smoother: directed and random
// transfers checked against a behavioral predictor held in a small scoreboard.
// Depends on fssm_pkg, fssm_if and fan_speed_slew_limited_smoother.

module tb_fan_speed_slew_limited_smoother
   import fssm_pkg::*;
();

   localparam int         CHANNELS      = 2;
   localparam logic [1:0] OP_UNUSED     = 2'd3;   // undefined opcode, acts as a read
   localparam int         ITEMS_PER_SET = 220;
   localparam int         RANDOM_SETS   = 8;
   localparam int         LONG_HOLD     = 200;
   localparam int         CYCLE_LIMIT   = 500000;

   // One result of the block: echoed channel, speed and reject flag
   typedef struct packed {
      logic        channel;
      logic [15:0] rpm;
      logic        bad;
   } speed_result_type;

   // Tracks per-channel smoothed speeds and the expected result stream
   class fan_speed_tracker;
      logic [10:0]      alpha;
      logic [15:0]      slew_max;
      logic [15:0]      zero_floor;
      logic [1:0]       active_ch;
      logic [15:0]      speed [CHANNELS];
      speed_result_type expected_speeds [$];
      int               errors, results;
      int               n_update, n_seed, n_read, n_bad, n_clamped, n_floored, n_saturated;

      function new();
         alpha      = ALPHA_RST;
         slew_max   = STEP_LIMIT_RST;
         zero_floor = ZERO_FLOOR_RST;
         active_ch  = ACTIVE_CH_RST;
         foreach (speed[i]) speed[i] = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_ALPHA:           alpha      = value[10:0];
            CSR_STEP_LIMIT:      slew_max   = value;
            CSR_ZERO_FLOOR:      zero_floor = value;
            CSR_ACTIVE_CHANNELS: active_ch  = value[1:0];
            default: ;
         endcase
      endfunction

      // Readings 1..255 are in hundreds of RPM, anything else is RPM
      function logic [15:0] to_rpm(logic [15:0] raw);
         if (raw >= 16'd1 && raw <= 16'd255) return raw * 16'd100;
         return raw;
      endfunction

      // One filter step: gain, floor shift, slew clamp, saturate, zero floor
      function logic [15:0] smooth_step(logic [15:0] cur, logic [15:0] target);
         longint delta, gain, step, lim, nxt;
         delta = target;
         delta = delta - longint'(cur);
         gain  = alpha;
         lim   = slew_max;
         step  = (delta * gain) >>> 10;
         if (step > lim) begin
            step = lim;
            n_clamped++;
         end else if (step < -lim) begin
            step = -lim;
            n_clamped++;
         end
         nxt = cur;
         nxt = nxt + step;
         if (nxt < 0) begin
            nxt = 0;
            n_saturated++;
         end
         if (nxt > 65535) begin
            nxt = 65535;
            n_saturated++;
         end
         if (nxt < longint'(zero_floor) && nxt != 0) n_floored++;
         if (nxt < longint'(zero_floor)) nxt = 0;
         return nxt[15:0];
      endfunction

      // Note an accepted request and queue the result it must produce
      function void note_request(logic [1:0] op, logic ch, logic [15:0] raw);
         speed_result_type exp_res;
         logic [15:0]      rpm;
         rpm = to_rpm(raw);
         exp_res.channel = ch;
         if (ch >= active_ch || ch >= CHANNELS) begin
            exp_res.rpm = '0;
            exp_res.bad = 1'b1;
            n_bad++;
         end else begin
            if (op == OP_UPDATE) begin
               speed[ch] = smooth_step(speed[ch], rpm);
               n_update++;
            end else if (op == OP_SEED) begin
               speed[ch] = rpm;
               n_seed++;
            end else begin
               n_read++;
            end
            exp_res.rpm = speed[ch];
            exp_res.bad = 1'b0;
         end
         expected_speeds.push_back(exp_res);
      endfunction

      // Compare an accepted result with the oldest expectation
      function void check_response(logic ch, logic [15:0] rpm, logic bad);
         speed_result_type exp_res;
         results++;
         if (expected_speeds.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result %0d: ch=%0d rpm=%0d bad=%0d",
                        results, ch, rpm, bad);
            return;
         end
         exp_res = expected_speeds.pop_front();
         if (ch !== exp_res.channel || rpm !== exp_res.rpm || bad !== exp_res.bad) begin
            errors++;
            if (errors <= 10)
               $display("mismatch on result %0d: expected ch=%0d rpm=%0d bad=%0d, %s",
                        results, exp_res.channel, exp_res.rpm, exp_res.bad,
                        $sformatf("got ch=%0d rpm=%0d bad=%0d", ch, rpm, bad));
         end
      endfunction

      function int pending();
         return expected_speeds.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycles;
   bit   tx_gaps_on;
   bit   rx_stalls_on;
   bit   long_hold_req;
   int   long_holds;
   int   settings;
   int   sent;

   fan_speed_tracker tracker = new();

   fssm_req_if req_if ();
   fssm_rsp_if rsp_if ();
   fssm_csr_if csr_if ();

   fan_speed_slew_limited_smoother #(.CHANNELS(CHANNELS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Mostly short idle stretches, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Observe every transfer at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            tracker.note_request(req_if.opcode, req_if.channel, req_if.raw_reading);
         if (rsp_if.valid && rsp_if.ready)
            tracker.check_response(rsp_if.channel_echo, rsp_if.smoothed_rpm,
                                   rsp_if.bad_channel);
         if (csr_if.valid && csr_if.ready)
            tracker.write_reg(csr_index_type'(csr_if.index), csr_if.wdata);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("fan_speed_slew_limited_smoother regression: fail");
         $finish;
      end
   end

   // Response side: take results, stall at random, or hold off for a long stretch
   initial begin
      int hold;
      rsp_if.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_if.ready <= 1'b0;
            for (hold = 0; hold < LONG_HOLD; hold++) @(negedge clock);
            long_hold_req = 1'b0;
            long_holds++;
         end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat (idle_len()) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Offer one request and hold it until the transfer; call at a falling edge
   task automatic send_item(logic [1:0] op, logic ch, logic [15:0] raw);
      int gap;
      gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.opcode      <= op;
      req_if.channel     <= ch;
      req_if.raw_reading <= raw;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      sent++;
   endtask

   // Write one register and hold it until the transfer
   task automatic csr_write(csr_index_type idx, logic [15:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= value;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
   endtask

   // Load all four registers; junk in the unused upper bits must be ignored
   task automatic set_config(int a, int lim, int flr, int act);
      logic [4:0]  a_junk;
      logic [13:0] act_junk;
      a_junk   = 5'($urandom);
      act_junk = 14'($urandom);
      csr_write(CSR_ALPHA, {a_junk, 11'(a)});
      csr_write(CSR_STEP_LIMIT, 16'(lim));
      csr_write(CSR_ZERO_FLOOR, 16'(flr));
      csr_write(CSR_ACTIVE_CHANNELS, {act_junk, 2'(act)});
      csr_if.valid <= 1'b0;
      settings++;
   endtask

   // Drop valid and drain every outstanding result
   task automatic drain();
      req_if.valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_raw();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)  return 16'($urandom_range(1, 255));
      if (r == 4) return 16'd0;
      if (r == 5) return 16'hFFFF;
      if (r == 6) return 16'($urandom_range(256, 400));
      return 16'($urandom);
   endfunction

   function automatic logic [1:0] pick_op();
      int r;
      r = $urandom_range(0, 19);
      if (r < 11) return OP_UPDATE;
      if (r < 14) return OP_SEED;
      if (r < 18) return OP_READ;
      return OP_UNUSED;
   endfunction

   // Pick a register set; alpha and step limit extremes a quarter of the time each
   task automatic random_config();
      int a, lim, flr, act, r;
      r = $urandom_range(0, 3);
      a = (r == 0) ? 0 : (r == 1) ? 2047 : (r == 2) ? 1024 : $urandom_range(0, 2047);
      r = $urandom_range(0, 3);
      lim = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(1, 4000);
      r = $urandom_range(0, 5);
      flr = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(1, 600);
      r = $urandom_range(0, 9);
      act = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 3 : 2;
      set_config(a, lim, flr, act);
   endtask

   initial begin
      logic [15:0] target [CHANNELS];
      logic        ch;
      logic [15:0] raw;
      int          ph, n;

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.opcode      = OP_UPDATE;
      req_if.channel     = 1'b0;
      req_if.raw_reading = '0;
      csr_if.valid       = 1'b0;
      csr_if.index       = CSR_ALPHA;
      csr_if.wdata       = '0;
      tx_gaps_on         = 1'b0;
      rx_stalls_on       = 1'b0;
      long_hold_req      = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: scaling edges, slow filter, undefined opcode
      send_item(OP_READ,   1'b0, 16'd0);
      send_item(OP_UPDATE, 1'b0, 16'd0);
      send_item(OP_SEED,   1'b0, 16'd255);
      send_item(OP_UPDATE, 1'b0, 16'd0);
      send_item(OP_UPDATE, 1'b0, 16'hFFFF);
      send_item(OP_SEED,   1'b1, 16'd1);
      send_item(OP_UPDATE, 1'b1, 16'd256);
      send_item(OP_UNUSED, 1'b1, 16'hFFFF);
      drain();

      // Full gain, high floor, one channel: floor kill, unfloored seed, rejects
      set_config(1024, 65535, 300, 1);
      send_item(OP_SEED,   1'b0, 16'd290);
      send_item(OP_UPDATE, 1'b0, 16'd256);
      send_item(OP_SEED,   1'b0, 16'd1000);
      send_item(OP_UPDATE, 1'b0, 16'd290);
      send_item(OP_UPDATE, 1'b1, 16'd500);
      send_item(OP_READ,   1'b1, 16'd0);
      drain();

      // Overshooting gain: saturate at the top, clamp down to zero; three active channels
      set_config(2047, 65535, 0, 3);
      send_item(OP_SEED,   1'b1, 16'd1000);
      send_item(OP_UPDATE, 1'b1, 16'hFFFF);
      send_item(OP_UPDATE, 1'b1, 16'd0);
      send_item(OP_SEED,   1'b0, 16'hAAAA);
      send_item(OP_UPDATE, 1'b0, 16'h5555);
      drain();

      // No active channels: everything rejected
      set_config(20, 0, 0, 0);
      send_item(OP_UPDATE, 1'b0, 16'd100);
      send_item(OP_SEED,   1'b1, 16'd100);
      drain();

      // Zero step limit: speed must not move
      set_config(512, 0, 0, 2);
      send_item(OP_UPDATE, 1'b0, 16'd0);
      drain();

      // Random sets under varied settings and flow control
      for (ph = 0; ph < RANDOM_SETS; ph++) begin
         case (ph)
            0:       set_config(0, 65535, 0, 2);
            1:       set_config(2047, 1, 65535, 2);
            2:       set_config(1024, 65535, 0, 2);
            default: random_config();
         endcase
         tx_gaps_on   = (ph != 0);
         rx_stalls_on = (ph != 0) && (ph != 3);
         if (ph == 3) long_hold_req = 1'b1;
         foreach (target[i]) target[i] = pick_raw();
         for (n = 0; n < ITEMS_PER_SET; n++) begin
            ch = 1'($urandom);
            if ($urandom_range(0, 15) == 0) target[ch] = pick_raw();
            raw = $urandom_range(0, 1) ? target[ch] : pick_raw();
            send_item(pick_op(), ch, raw);
         end
         drain();
      end

      $display("covered %0d items: %0d updates (%0d slew-limited, %0d floored,",
               sent, tracker.n_update, tracker.n_clamped, tracker.n_floored);
      $display("  %0d saturated), %0d seeds, %0d reads, %0d rejected channels",
               tracker.n_saturated, tracker.n_seed, tracker.n_read, tracker.n_bad);
      $display("%0d register settings, %0d long output holds, %0d errors",
               settings, long_holds, tracker.errors);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("fan_speed_slew_limited_smoother regression: pass");
      else
         $display("fan_speed_slew_limited_smoother regression: fail");
      $finish;
   end

endmodule
